[rtl/core/qap_pkg.sv]
// Shared types and constants for the QAP swap local search core.
package qap_pkg;

   localparam int SIZE_N      = 8;
   localparam int IDX_W       = 3;
   localparam int ADDR_W      = 2 * IDX_W;
   localparam int DEPTH       = SIZE_N * SIZE_N;
   localparam int VALUE_W     = 16;
   localparam int AMOUNT_W    = 38;
   localparam int DEF_WEIGHT_BITS = 16;

   typedef enum logic [1:0] {
      ACT_LOAD_COST = 2'd0,
      ACT_LOAD_FLOW = 2'd1,
      ACT_LOAD_PERM = 2'd2,
      ACT_RUN       = 2'd3
   } action_type;

   typedef enum logic [1:0] {
      KIND_INITIAL = 2'd0,
      KIND_FINAL   = 2'd1,
      KIND_PERM    = 2'd2,
      KIND_UNUSED  = 2'd3
   } kind_type;

   typedef struct packed {
      action_type          action;
      logic [IDX_W-1:0]    row;
      logic [IDX_W-1:0]    col;
      logic [VALUE_W-1:0]  value;
   } req_type;

   typedef struct packed {
      kind_type            kind;
      logic [IDX_W-1:0]    position;
      logic [AMOUNT_W-1:0] amount;
      logic                last;
   } rsp_type;

endpackage

[rtl/core/qap_swap_local_search_core.sv]
// Top level: QAP pairwise swap hill climber with shared multiply-accumulate unit.
// Load requests (cost, flow or permutation entry) produce no response. A run request
// evaluates the objective with one multiply-accumulate per cycle within a row: for each
// row it reads the permutation entry, then issues the N products; after the last row the
// pipeline drains. One evaluation is for the start point and one per candidate swap,
// N*(N-1)/2 candidates per pass; ST_SWAPA and ST_SWAPB commit a kept swap and ST_NEXT
// moves to the next candidate. Passes repeat until one keeps no swap, so run time depends
// on the data. The N+2 responses (initial and final objective, N permutation entries,
// last flagged) leave one per cycle while rsp_ready is high; no request is accepted meanwhile.
module qap_swap_local_search_core
   import qap_pkg::*;
#(
   parameter int WEIGHT_BITS = DEF_WEIGHT_BITS
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   output rsp_type rsp_data
);

   localparam int ACC_W = 2 * WEIGHT_BITS + ADDR_W;
   localparam int KW    = $clog2(SIZE_N + 2);

   typedef enum logic [7:0] {
      ST_IDLE  = 8'b0000_0001,
      ST_ROWP  = 8'b0000_0010,
      ST_COLS  = 8'b0000_0100,
      ST_DRAIN = 8'b0000_1000,
      ST_SWAPA = 8'b0001_0000,
      ST_SWAPB = 8'b0010_0000,
      ST_NEXT  = 8'b0100_0000,
      ST_OUT   = 8'b1000_0000
   } state_type;

   state_type state_ff, state_in;

   logic [WEIGHT_BITS-1:0] cost_mem [DEPTH];
   logic [WEIGHT_BITS-1:0] flow_mem [DEPTH];
   logic [IDX_W-1:0]       perm_ff  [SIZE_N];

   logic [WEIGHT_BITS-1:0]   cost_rd_ff, flow_rd_ff;
   logic [2*WEIGHT_BITS-1:0] prod_ff;
   logic                     v1_ff, v2_ff;
   logic [ACC_W-1:0]         acc_ff, init_ff, cur_ff;
   logic [IDX_W-1:0]         i_ff, j_ff, si_ff, sj_ff, pi_ff, tmp_ff;
   logic                     swap_en_ff, first_ff, improved_ff;
   logic [KW-1:0]            k_ff;
   logic                     rsp_valid_ff;
   rsp_type                  rsp_data_ff;

   logic [IDX_W-1:0] perm_addr, perm_rd;
   logic             req_acc, issue, out_load, pipe_empty;

   function automatic logic [IDX_W-1:0] map_pos(input logic [IDX_W-1:0] k,
                                                input logic en,
                                                input logic [IDX_W-1:0] a,
                                                input logic [IDX_W-1:0] b);
      logic [IDX_W-1:0] r;
      r = k;
      if (en && k == a) r = b;
      else if (en && k == b) r = a;
      return r;
   endfunction

   assign req_ready  = (state_ff == ST_IDLE);
   assign req_acc    = req_valid && req_ready;
   assign issue      = (state_ff == ST_COLS);
   assign out_load   = (state_ff == ST_OUT) && (!rsp_valid_ff || rsp_ready);
   assign pipe_empty = !v1_ff && !v2_ff;

   always_comb begin
      unique case (state_ff)
         ST_ROWP:  perm_addr = map_pos(i_ff, swap_en_ff, si_ff, sj_ff);
         ST_COLS:  perm_addr = map_pos(j_ff, swap_en_ff, si_ff, sj_ff);
         ST_SWAPA: perm_addr = si_ff;
         ST_SWAPB: perm_addr = sj_ff;
         ST_OUT:   perm_addr = IDX_W'(k_ff - KW'(2));
         default:  perm_addr = i_ff;
      endcase
   end
   assign perm_rd = perm_ff[perm_addr];

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE:  if (req_acc && req_data.action == ACT_RUN) state_in = ST_ROWP;
         ST_ROWP:  state_in = ST_COLS;
         ST_COLS: begin
            if (j_ff == IDX_W'(SIZE_N - 1))
               state_in = (i_ff == IDX_W'(SIZE_N - 1)) ? ST_DRAIN : ST_ROWP;
         end
         ST_DRAIN: begin
            if (pipe_empty) begin
               if (first_ff) state_in = ST_ROWP;
               else if (acc_ff < cur_ff) state_in = ST_SWAPA;
               else state_in = ST_NEXT;
            end
         end
         ST_SWAPA: state_in = ST_SWAPB;
         ST_SWAPB: state_in = ST_NEXT;
         ST_NEXT: begin
            if (sj_ff == IDX_W'(SIZE_N - 1) && si_ff == IDX_W'(SIZE_N - 2) && !improved_ff)
               state_in = ST_OUT;
            else
               state_in = ST_ROWP;
         end
         ST_OUT:   if (out_load && k_ff == KW'(SIZE_N + 1)) state_in = ST_IDLE;
         default:  state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         v1_ff        <= 1'b0;
         v2_ff        <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         v1_ff    <= issue;
         v2_ff    <= v1_ff;
         if (out_load) rsp_valid_ff <= 1'b1;
         else if (rsp_ready) rsp_valid_ff <= 1'b0;
      end
   end

   // stores and shared multiply-accumulate datapath
   always_ff @(posedge clock) begin
      if (req_acc && req_data.action == ACT_LOAD_COST)
         cost_mem[{req_data.row, req_data.col}] <= WEIGHT_BITS'(req_data.value);
      if (req_acc && req_data.action == ACT_LOAD_FLOW)
         flow_mem[{req_data.row, req_data.col}] <= WEIGHT_BITS'(req_data.value);
      cost_rd_ff <= cost_mem[{i_ff, j_ff}];
      flow_rd_ff <= flow_mem[{pi_ff, perm_rd}];
      prod_ff    <= cost_rd_ff * flow_rd_ff;
      if (v2_ff) acc_ff <= acc_ff + ACC_W'(prod_ff);

      if (req_acc && req_data.action == ACT_LOAD_PERM)
         perm_ff[req_data.row] <= req_data.value[IDX_W-1:0];

      unique case (state_ff)
         ST_IDLE: begin
            i_ff        <= '0;
            j_ff        <= '0;
            acc_ff      <= '0;
            swap_en_ff  <= 1'b0;
            first_ff    <= 1'b1;
            improved_ff <= 1'b0;
            si_ff       <= '0;
            sj_ff       <= IDX_W'(1);
            k_ff        <= '0;
         end
         ST_ROWP: begin
            pi_ff <= perm_rd;
            j_ff  <= '0;
         end
         ST_COLS: begin
            j_ff <= j_ff + IDX_W'(1);
            if (j_ff == IDX_W'(SIZE_N - 1)) i_ff <= i_ff + IDX_W'(1);
         end
         ST_DRAIN: begin
            if (pipe_empty) begin
               i_ff <= '0;
               if (first_ff) begin
                  init_ff    <= acc_ff;
                  cur_ff     <= acc_ff;
                  first_ff   <= 1'b0;
                  swap_en_ff <= 1'b1;
                  acc_ff     <= '0;
               end else if (acc_ff < cur_ff) begin
                  cur_ff      <= acc_ff;
                  improved_ff <= 1'b1;
               end
            end
         end
         ST_SWAPA: tmp_ff <= perm_rd;
         ST_SWAPB: begin
            perm_ff[si_ff] <= perm_rd;
            perm_ff[sj_ff] <= tmp_ff;
         end
         ST_NEXT: begin
            acc_ff <= '0;
            i_ff   <= '0;
            if (sj_ff == IDX_W'(SIZE_N - 1)) begin
               if (si_ff == IDX_W'(SIZE_N - 2)) begin
                  si_ff       <= '0;
                  sj_ff       <= IDX_W'(1);
                  improved_ff <= 1'b0;
               end else begin
                  si_ff <= si_ff + IDX_W'(1);
                  sj_ff <= si_ff + IDX_W'(2);
               end
            end else begin
               sj_ff <= sj_ff + IDX_W'(1);
            end
         end
         ST_OUT: begin
            if (out_load) begin
               k_ff <= k_ff + KW'(1);
               if (k_ff == KW'(0)) begin
                  rsp_data_ff.kind     <= KIND_INITIAL;
                  rsp_data_ff.position <= '0;
                  rsp_data_ff.amount   <= AMOUNT_W'(init_ff);
                  rsp_data_ff.last     <= 1'b0;
               end else if (k_ff == KW'(1)) begin
                  rsp_data_ff.kind     <= KIND_FINAL;
                  rsp_data_ff.position <= '0;
                  rsp_data_ff.amount   <= AMOUNT_W'(cur_ff);
                  rsp_data_ff.last     <= 1'b0;
               end else begin
                  rsp_data_ff.kind     <= KIND_PERM;
                  rsp_data_ff.position <= perm_addr;
                  rsp_data_ff.amount   <= AMOUNT_W'(perm_rd);
                  rsp_data_ff.last     <= (k_ff == KW'(SIZE_N + 1));
               end
            end
         end
         default: ;
      endcase
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

`ifndef ASSERT_OFF
   a_busy_not_ready: assert property (@(posedge clock) disable iff (reset)
      state_ff != ST_IDLE |-> !req_ready) else $error("ready while busy");
   a_pipe_order: assert property (@(posedge clock) disable iff (reset)
      v2_ff |-> $past(v1_ff)) else $error("pipeline valid out of order");
   a_swap_order: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DRAIN && !first_ff) |-> si_ff < sj_ff) else $error("bad swap pair");
   a_last_perm: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.last) |-> rsp_data.kind == KIND_PERM)
      else $error("last on non-permutation response");
`endif

endmodule

[test/qap_swap_local_search_core_tb.sv]
// Testbench for the QAP swap local search core: random loads and runs checked against a predictor.
`timescale 1ns / 1ps

module qap_swap_local_search_core_tb;
   import qap_pkg::*;

   localparam int LIMIT = 4000000;

   logic    clock;
   logic    reset;
   logic    req_valid;
   logic    req_ready;
   req_type req_data;
   logic    rsp_valid;
   logic    rsp_ready;
   rsp_type rsp_data;

   req_type pending_reqs[$];
   rsp_type expected_rsps[$];
   int      errors = 0;
   int      cycle;

   logic [VALUE_W-1:0] cost_m [SIZE_N][SIZE_N];
   logic [VALUE_W-1:0] flow_m [SIZE_N][SIZE_N];
   logic [IDX_W-1:0]   perm_m [SIZE_N];

   qap_swap_local_search_core dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_data(rsp_data)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   function automatic logic [63:0] objective();
      logic [63:0] sum;
      sum = '0;
      for (int i = 0; i < SIZE_N; i++)
         for (int j = 0; j < SIZE_N; j++)
            sum += 64'(cost_m[i][j]) * 64'(flow_m[perm_m[i]][perm_m[j]]);
      return sum;
   endfunction

   function automatic rsp_type make_rsp(kind_type k, int pos, logic [63:0] amt, logic lst);
      rsp_type r;
      r.kind = k;
      r.position = IDX_W'(pos);
      r.amount = amt[AMOUNT_W-1:0];
      r.last = lst;
      return r;
   endfunction

   task automatic predict_request(req_type r);
      logic [63:0]      initial_obj, current, trial;
      logic             improved;
      logic [IDX_W-1:0] t;
      case (r.action)
         ACT_LOAD_COST: cost_m[r.row][r.col] = r.value;
         ACT_LOAD_FLOW: flow_m[r.row][r.col] = r.value;
         ACT_LOAD_PERM: perm_m[r.row] = r.value[IDX_W-1:0];
         default: begin
            initial_obj = objective();
            current = initial_obj;
            improved = 1'b1;
            while (improved) begin
               improved = 1'b0;
               for (int i = 0; i < SIZE_N - 1; i++)
                  for (int j = i + 1; j < SIZE_N; j++) begin
                     t = perm_m[i];
                     perm_m[i] = perm_m[j];
                     perm_m[j] = t;
                     trial = objective();
                     if (trial < current) begin
                        current = trial;
                        improved = 1'b1;
                     end else begin
                        perm_m[j] = perm_m[i];
                        perm_m[i] = t;
                     end
                  end
            end
            expected_rsps.push_back(make_rsp(KIND_INITIAL, 0, initial_obj, 1'b0));
            expected_rsps.push_back(make_rsp(KIND_FINAL, 0, current, 1'b0));
            for (int i = 0; i < SIZE_N; i++)
               expected_rsps.push_back(make_rsp(KIND_PERM, i, 64'(perm_m[i]),
                                                i == SIZE_N - 1));
         end
      endcase
   endtask

   function automatic logic idle_now();
      if ((cycle % 60000) < 10000) return 1'b0;
      return $urandom_range(0, 99) < 33;
   endfunction

   function automatic req_type make_req(action_type a, int rw, int cl, int v);
      req_type r;
      r.action = a;
      r.row = IDX_W'(rw);
      r.col = IDX_W'(cl);
      r.value = VALUE_W'(v);
      return r;
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         req_data <= '0;
         rsp_ready <= 1'b0;
         cycle <= 0;
      end else begin
         cycle <= cycle + 1;
         if (req_valid && req_ready) predict_request(req_data);
         if (!req_valid || req_ready) begin
            if (pending_reqs.size() != 0 && !idle_now()) begin
               req_data <= pending_reqs.pop_front();
               req_valid <= 1'b1;
            end else begin
               req_valid <= 1'b0;
            end
         end
         rsp_ready <= !idle_now();
      end
   end

   always @(posedge clock) begin
      rsp_type e;
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_rsps.size() == 0) begin
            $error("unexpected response %h", rsp_data);
            errors++;
         end else begin
            e = expected_rsps.pop_front();
            if (rsp_data.kind !== e.kind) begin
               $error("kind: expected %0d actual %0d", e.kind, rsp_data.kind);
               errors++;
            end
            if (rsp_data.position !== e.position) begin
               $error("position: expected %0d actual %0d", e.position, rsp_data.position);
               errors++;
            end
            if (rsp_data.amount !== e.amount) begin
               $error("amount: expected %0d actual %0d", e.amount, rsp_data.amount);
               errors++;
            end
            if (rsp_data.last !== e.last) begin
               $error("last: expected %0d actual %0d", e.last, rsp_data.last);
               errors++;
            end
         end
      end
   end

   always @(posedge clock) begin
      if (cycle > LIMIT) begin
         $display("qap_swap_local_search_core: mismatch");
         $finish;
      end
   end

   initial begin
      int n;
      int total;
      reset = 1'b1;
      // full fill at maximum weight, identity permutation
      for (int i = 0; i < SIZE_N; i++)
         for (int j = 0; j < SIZE_N; j++) begin
            pending_reqs.push_back(make_req(ACT_LOAD_COST, i, j, 65535));
            pending_reqs.push_back(make_req(ACT_LOAD_FLOW, i, j, 65535));
         end
      for (int i = 0; i < SIZE_N; i++)
         pending_reqs.push_back(make_req(ACT_LOAD_PERM, i, 7 - i, i));
      pending_reqs.push_back(make_req(ACT_RUN, 7, 7, 65535));
      // zero weights on row 0, duplicate and wide permutation values
      for (int j = 0; j < SIZE_N; j++)
         pending_reqs.push_back(make_req(ACT_LOAD_COST, 0, j, 0));
      pending_reqs.push_back(make_req(ACT_LOAD_PERM, 0, 0, 65535));
      pending_reqs.push_back(make_req(ACT_LOAD_PERM, 1, 0, 65527));
      pending_reqs.push_back(make_req(ACT_LOAD_PERM, 2, 5, 32771));
      pending_reqs.push_back(make_req(ACT_RUN, 0, 0, 0));
      // random full fill
      for (int i = 0; i < SIZE_N; i++)
         for (int j = 0; j < SIZE_N; j++) begin
            pending_reqs.push_back(make_req(ACT_LOAD_COST, i, j, $urandom_range(0, 65535)));
            pending_reqs.push_back(make_req(ACT_LOAD_FLOW, i, j, $urandom_range(0, 65535)));
         end
      for (int i = 0; i < SIZE_N; i++)
         pending_reqs.push_back(make_req(ACT_LOAD_PERM, i, $urandom_range(0, 7),
                                         $urandom_range(0, 65535)));
      pending_reqs.push_back(make_req(ACT_RUN, 3, 4, $urandom_range(0, 65535)));
      total = pending_reqs.size();
      while (total < 370) begin
         n = $urandom_range(0, 12);
         for (int k = 0; k < n; k++) begin
            int v;
            case ($urandom_range(0, 5))
               0: v = 0;
               1: v = 65535;
               default: v = $urandom_range(0, 65535);
            endcase
            pending_reqs.push_back(make_req(action_type'($urandom_range(0, 2)),
                                            $urandom_range(0, 7), $urandom_range(0, 7), v));
         end
         pending_reqs.push_back(make_req(ACT_RUN, $urandom_range(0, 7),
                                         $urandom_range(0, 7), $urandom_range(0, 65535)));
         total += n + 1;
      end
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      do @(posedge clock);
      while (pending_reqs.size() != 0 || req_valid || expected_rsps.size() != 0);
      repeat (200) @(posedge clock);
      if (errors == 0 && expected_rsps.size() == 0)
         $display("qap_swap_local_search_core: match");
      else
         $display("qap_swap_local_search_core: mismatch");
      $finish;
   end

endmodule
